// ----- hdl/drd_pkg.sv -----
// Package: shared constants, register codes and structs of the detection row decoder.
`default_nettype none
package drd_pkg;

	localparam int VALUE_W     = 32;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_CLASSES = 64;
	localparam int BOX_FIELDS  = 4;
	localparam int POS_OBJECT  = 4;
	localparam int POS_CLASS0  = 5;
	localparam int POS_W       = 7;
	localparam int LABEL_W     = 6;
	localparam int CC_W        = 7;
	localparam int THR_W       = 17;
	localparam int SIZE_W      = 11;
	localparam int MAX_SIDE    = 1024;
	localparam int LEFT_W      = 26;
	localparam int RIGHT_W     = 32;
	localparam int SCORE_W     = 17;
	localparam int PROD_W      = 2 * VALUE_W;
	localparam int CORNER_W    = VALUE_W + 1;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_FIELD_W = 2 * LEFT_W + 2 * RIGHT_W + SCORE_W + LABEL_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	typedef enum logic [1:0] {
		REG_CLASS_COUNT,
		REG_OBJECT_THRESHOLD,
		REG_SCORE_THRESHOLD,
		REG_IMAGE_SIDE
	} reg_index_t;

	typedef struct packed {
		logic [CC_W-1:0]   class_count;
		logic [THR_W-1:0]  object_threshold;
		logic [THR_W-1:0]  score_threshold;
		logic [SIZE_W-1:0] image_side;
	} cfg_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] cx;
		logic signed [VALUE_W-1:0] cy;
		logic signed [VALUE_W-1:0] w;
		logic signed [VALUE_W-1:0] h;
		logic signed [VALUE_W-1:0] obj;
		logic signed [VALUE_W-1:0] best;
		logic [LABEL_W-1:0]        label;
	} row_t;

	typedef struct packed {
		logic row_end;
		logic row_valid;
	} row_stat_t;

endpackage
`default_nettype wire

// ----- hdl/drd_cfg.sv -----
// Configuration registers behind an APB-style port.
`default_nettype none
module drd_cfg
	import drd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	reg_index_t idx;
	logic       wr_en;

	assign idx    = reg_index_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.class_count      <= CC_W'(9);
			cfg.object_threshold <= THR_W'(32768);
			cfg.score_threshold  <= THR_W'(32768);
			cfg.image_side       <= SIZE_W'(320);
		end else if (wr_en) begin
			unique case (idx)
				REG_CLASS_COUNT:      cfg.class_count      <= pwdata[CC_W-1:0];
				REG_OBJECT_THRESHOLD: cfg.object_threshold <= pwdata[THR_W-1:0];
				REG_SCORE_THRESHOLD:  cfg.score_threshold  <= pwdata[THR_W-1:0];
				REG_IMAGE_SIDE:       cfg.image_side       <= pwdata[SIZE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CLASS_COUNT:      prdata = APB_DATA_W'(cfg.class_count);
			REG_OBJECT_THRESHOLD: prdata = APB_DATA_W'(cfg.object_threshold);
			REG_SCORE_THRESHOLD:  prdata = APB_DATA_W'(cfg.score_threshold);
			REG_IMAGE_SIDE:       prdata = APB_DATA_W'(cfg.image_side);
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/drd_row.sv -----
// Row tracker: box fields, objectness, running argmax and the row snapshot register.
`default_nettype none
module drd_row
	import drd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic                  row_ready,
	output row_t                       row_s1,
	output row_stat_t                  stat
);

	logic [POS_W-1:0]          pos_q;
	logic signed [VALUE_W-1:0] box_q [BOX_FIELDS];
	logic signed [VALUE_W-1:0] obj_q;
	logic signed [VALUE_W-1:0] best_q;
	logic [LABEL_W-1:0]        label_q;
	logic                      row_valid_s1;

	logic [CC_W-1:0]           classes;
	logic [POS_W-1:0]          last_pos;
	logic                      row_end;
	logic                      accept;
	logic                      s1_can_load;
	logic signed [VALUE_W-1:0] v;
	logic signed [VALUE_W-1:0] best_nxt;
	logic [LABEL_W-1:0]        label_nxt;
	logic [POS_W-1:0]          class_pos;

	assign v = $signed(s_tdata[VALUE_W-1:0]);

	always_comb begin
		priority if (cfg.class_count == '0) begin
			classes = CC_W'(1);
		end else if (cfg.class_count > CC_W'(MAX_CLASSES)) begin
			classes = CC_W'(MAX_CLASSES);
		end else begin
			classes = cfg.class_count;
		end
	end

	assign last_pos    = POS_W'(classes) + POS_W'(POS_OBJECT);
	assign row_end     = pos_q >= last_pos;
	assign s1_can_load = !row_valid_s1 || row_ready;
	assign s_tready    = !row_end || s1_can_load;
	assign accept      = s_tvalid && s_tready;
	assign class_pos   = pos_q - POS_W'(POS_CLASS0);

	always_comb begin
		best_nxt  = best_q;
		label_nxt = label_q;
		priority if (pos_q == POS_W'(POS_CLASS0)) begin
			best_nxt  = v;
			label_nxt = '0;
		end else if (pos_q > POS_W'(POS_CLASS0) && v > best_q) begin
			best_nxt  = v;
			label_nxt = class_pos[LABEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			row_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= row_end ? '0 : pos_q + POS_W'(1);
			end
			if (s1_can_load) begin
				row_valid_s1 <= accept && row_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q < POS_W'(BOX_FIELDS)) begin
				box_q[pos_q[1:0]] <= v;
			end
			if (pos_q == POS_W'(POS_OBJECT)) begin
				obj_q <= v;
			end
			best_q  <= best_nxt;
			label_q <= label_nxt;
		end
		if (accept && row_end && s1_can_load) begin
			row_s1.cx    <= box_q[0];
			row_s1.cy    <= box_q[1];
			row_s1.w     <= box_q[2];
			row_s1.h     <= box_q[3];
			row_s1.obj   <= obj_q;
			row_s1.best  <= best_nxt;
			row_s1.label <= label_nxt;
		end
	end

	assign stat.row_end   = row_end;
	assign stat.row_valid = row_valid_s1;

endmodule
`default_nettype wire

// ----- hdl/drd_calc.sv -----
// Result path: product and corners, then thresholds, clamps, saturation and output register.
`default_nettype none
module drd_calc
	import drd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire row_t                   row_s1,
	input  wire row_stat_t              stat,
	output logic                        row_ready,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [OUT_TDATA_W-1:0] m_tdata
);

	// stage 2
	logic                       v_s2;
	logic                       obj_ok_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [CORNER_W-1:0] x1_s2;
	logic signed [CORNER_W-1:0] y1_s2;
	logic signed [CORNER_W-1:0] x2_s2;
	logic signed [CORNER_W-1:0] y2_s2;
	logic [LABEL_W-1:0]         label_s2;

	// output register
	logic                       m_tvalid_q;
	logic [LEFT_W-1:0]          left_q;
	logic [LEFT_W-1:0]          top_q;
	logic [RIGHT_W-1:0]         right_q;
	logic [RIGHT_W-1:0]         bottom_q;
	logic [SCORE_W-1:0]         score_q;
	logic [LABEL_W-1:0]         label_q;

	logic                       out_can_load;
	logic                       load_s2;
	logic signed [VALUE_W-1:0]  obj_thr;
	logic signed [PROD_W-1:0]   prod;
	logic signed [CORNER_W:0]   cx2;
	logic signed [CORNER_W:0]   cy2;
	logic signed [CORNER_W:0]   w_e;
	logic signed [CORNER_W:0]   h_e;
	logic signed [CORNER_W:0]   dx1;
	logic signed [CORNER_W:0]   dy1;
	logic signed [CORNER_W:0]   dx2;
	logic signed [CORNER_W:0]   dy2;

	logic signed [PROD_W-1:0]   need;
	logic                       keep;
	logic [PROD_W-FRAC_BITS-1:0] conf_full;
	logic [SCORE_W-1:0]         conf;
	logic [SIZE_W-1:0]          side;
	logic [SIZE_W-2:0]          side_m1;
	logic [LEFT_W-1:0]          limit;
	logic signed [CORNER_W-1:0] limit_e;
	logic signed [CORNER_W-1:0] low_e;
	logic [LEFT_W-1:0]          left_c;
	logic [LEFT_W-1:0]          top_c;
	logic [RIGHT_W-1:0]         right_c;
	logic [RIGHT_W-1:0]         bottom_c;

	assign out_can_load = !m_tvalid_q || m_tready;
	assign row_ready    = !v_s2 || out_can_load;
	assign load_s2      = stat.row_valid && row_ready;

	assign obj_thr = $signed({{(VALUE_W-THR_W){1'b0}}, cfg.object_threshold});
	assign prod    = row_s1.obj * row_s1.best;
	assign cx2     = {row_s1.cx[VALUE_W-1], row_s1.cx, 1'b0};
	assign cy2     = {row_s1.cy[VALUE_W-1], row_s1.cy, 1'b0};
	assign w_e     = {{2{row_s1.w[VALUE_W-1]}}, row_s1.w};
	assign h_e     = {{2{row_s1.h[VALUE_W-1]}}, row_s1.h};
	assign dx1     = cx2 - w_e;
	assign dy1     = cy2 - h_e;
	assign dx2     = cx2 + w_e;
	assign dy2     = cy2 + h_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (row_ready) begin
			v_s2 <= stat.row_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			obj_ok_s2 <= row_s1.obj >= obj_thr;
			prod_s2   <= prod;
			x1_s2     <= dx1[CORNER_W:1];
			y1_s2     <= dy1[CORNER_W:1];
			x2_s2     <= dx2[CORNER_W:1];
			y2_s2     <= dy2[CORNER_W:1];
			label_s2  <= row_s1.label;
		end
	end

	assign need = $signed({{(PROD_W-THR_W-FRAC_BITS){1'b0}}, cfg.score_threshold,
		{FRAC_BITS{1'b0}}});
	assign keep      = obj_ok_s2 && (prod_s2 >= need);
	assign conf_full = prod_s2[PROD_W-1:FRAC_BITS];
	assign conf      = (conf_full > (PROD_W-FRAC_BITS)'(1 << FRAC_BITS))
		? SCORE_W'(1 << FRAC_BITS) : conf_full[SCORE_W-1:0];

	always_comb begin
		priority if (cfg.image_side == '0) begin
			side = SIZE_W'(1);
		end else if (cfg.image_side > SIZE_W'(MAX_SIDE)) begin
			side = SIZE_W'(MAX_SIDE);
		end else begin
			side = cfg.image_side;
		end
	end

	assign side_m1 = side[SIZE_W-2:0] - (SIZE_W-1)'(1);
	assign limit   = {side_m1, {FRAC_BITS{1'b0}}};
	assign limit_e = $signed({{(CORNER_W-LEFT_W){1'b0}}, limit});
	assign low_e   = $signed({2'b11, {(VALUE_W-1){1'b0}}});

	always_comb begin
		priority if (x1_s2 < 0) begin
			left_c = '0;
		end else if (x1_s2 > limit_e) begin
			left_c = limit;
		end else begin
			left_c = x1_s2[LEFT_W-1:0];
		end
		priority if (y1_s2 < 0) begin
			top_c = '0;
		end else if (y1_s2 > limit_e) begin
			top_c = limit;
		end else begin
			top_c = y1_s2[LEFT_W-1:0];
		end
		priority if (x2_s2 < low_e) begin
			right_c = low_e[RIGHT_W-1:0];
		end else if (x2_s2 > limit_e) begin
			right_c = RIGHT_W'(limit);
		end else begin
			right_c = x2_s2[RIGHT_W-1:0];
		end
		priority if (y2_s2 < low_e) begin
			bottom_c = low_e[RIGHT_W-1:0];
		end else if (y2_s2 > limit_e) begin
			bottom_c = RIGHT_W'(limit);
		end else begin
			bottom_c = y2_s2[RIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_can_load) begin
			m_tvalid_q <= v_s2 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (out_can_load && v_s2 && keep) begin
			left_q   <= left_c;
			top_q    <= top_c;
			right_q  <= right_c;
			bottom_q <= bottom_c;
			score_q  <= conf;
			label_q  <= label_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, label_q, score_q, bottom_q, right_q,
		top_q, left_q};

endmodule
`default_nettype wire

// ----- hdl/detection_row_decoder.sv -----
// Top level of the detection row decoder: configuration, row tracker and result path.
`default_nettype none
// Takes one tensor element per cycle while s_tready is high, in rows of class_count + 5
// elements (class_count clamped to 1..64): cx, cy, w, h, objectness, class scores. The
// running argmax keeps pace with the stream, so it never holds up an element; the result
// of a kept row is valid on m_tvalid once it has passed the row snapshot (loaded at the
// edge that accepts the row's last element), the multiply stage and the output register,
// and rows that fail a threshold leave nothing. s_tready falls only on a row's last
// element while the snapshot, multiply and output registers all hold rows not yet taken.
module detection_row_decoder
	import drd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_ADDR_W-1:0]  paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	output logic      [APB_DATA_W-1:0]  prdata,
	output logic                        pready,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // tensor_value[31:0]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// left[25:0], top[51:26], right[83:52], bottom[115:84], score[132:116],
	// label[138:133], zero[143:139]
	output logic      [OUT_TDATA_W-1:0] m_tdata
);

	cfg_t      cfg;
	row_t      row_s1;
	row_stat_t stat;
	logic      row_ready;

	drd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	drd_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.row_ready (row_ready),
		.row_s1    (row_s1),
		.stat      (stat)
	);

	drd_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.row_s1    (row_s1),
		.stat      (stat),
		.row_ready (row_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	a_stall_only_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (stat.row_end && stat.row_valid && !row_ready))
		else $error("input stalled outside a blocked row end");

	a_row_end_snapshot: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && stat.row_end) |=> stat.row_valid)
		else $error("row end item did not load the snapshot");

	a_not_row_end_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && stat.row_end) |=> !stat.row_end)
		else $error("row position did not restart after a row end");

endmodule
`default_nettype wire
